/* design/pjb_pkg.sv */
// shared types, codes and constants of the jitter buffer sequence-window controller
`default_nettype none

package pjb_pkg;

   localparam int SEQ_W    = 16;
   localparam int CFG_W    = 9;
   localparam int STATUS_W = 4;
   localparam int FUNC_W   = 2;
   localparam int CSR_IDX_W = 1;

   // item functions
   localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESYNC = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INORDER   = 4'd0;
   localparam logic [STATUS_W-1:0] ST_GAP       = 4'd1;
   localparam logic [STATUS_W-1:0] ST_LATEOK    = 4'd2;
   localparam logic [STATUS_W-1:0] ST_TOOLATE   = 4'd3;
   localparam logic [STATUS_W-1:0] ST_PLAYED    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_MISSING   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_UNDERRUN  = 4'd6;
   localparam logic [STATUS_W-1:0] ST_WAITING   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_RESTARTED = 4'd8;
   localparam logic [STATUS_W-1:0] ST_RESYNCED  = 4'd9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_FILL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD  = 1'b1;

   localparam logic [CFG_W-1:0] START_FILL_RST = 9'd282;
   localparam logic [CFG_W-1:0] LOOKAHEAD_RST  = 9'd10;

   typedef struct packed {
      logic load;
      logic arr_class;
      logic arr_fill;
      logic arr_store;
      logic mem_rd;
      logic arr_chk;
      logic fet_decide;
      logic fet_inc;
      logic fet_play;
      logic resync;
      logic clear;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fetch_play;
      logic clear_last;
   } sts_type;

endpackage

`default_nettype wire

/* design/pjb_ctrl.sv */
// controller state machine: sequences arrival, fetch, resync and ready-bit clearing
`default_nettype none

module pjb_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pjb_pkg::FUNC_W-1:0]    req_func,
   input  wire pjb_pkg::sts_type              sts,
   output pjb_pkg::cmd_type                   cmd,
   output logic                               busy
);

   typedef enum logic [4:0] {
      S_CLEAR_BOOT,
      S_IDLE,
      S_A_CLASS,
      S_A_FILL,
      S_A_WAIT1,
      S_A_WAIT2,
      S_A_STORE,
      S_A_READ,
      S_A_CHK,
      S_F_DECIDE,
      S_F_INC,
      S_F_WAIT1,
      S_F_WAIT2,
      S_F_READ,
      S_F_PLAY,
      S_RESYNC,
      S_CLEAR_SYNC,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR_BOOT;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR_BOOT: begin
               if (sts.clear_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  unique case (req_func)
                     pjb_pkg::FUNC_ARRIVE: begin
                        state_ff <= S_A_CLASS;
                        busy_ff  <= 1'b1;
                     end
                     pjb_pkg::FUNC_FETCH: begin
                        state_ff <= S_F_DECIDE;
                        busy_ff  <= 1'b1;
                     end
                     pjb_pkg::FUNC_RESYNC: begin
                        state_ff <= S_RESYNC;
                        busy_ff  <= 1'b1;
                     end
                     default: begin
                        // unused function code: item dropped, no result
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_A_CLASS:  state_ff <= S_A_FILL;
            S_A_FILL:   state_ff <= S_A_WAIT1;
            S_A_WAIT1:  state_ff <= S_A_WAIT2;
            S_A_WAIT2:  state_ff <= S_A_STORE;
            S_A_STORE:  state_ff <= S_A_READ;
            S_A_READ:   state_ff <= S_A_CHK;
            S_A_CHK: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            S_F_DECIDE: state_ff <= sts.fetch_play ? S_F_INC : S_EMIT;
            S_F_INC:    state_ff <= S_F_WAIT1;
            S_F_WAIT1:  state_ff <= S_F_WAIT2;
            S_F_WAIT2:  state_ff <= S_F_READ;
            S_F_READ:   state_ff <= S_F_PLAY;
            S_F_PLAY: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            S_RESYNC:   state_ff <= S_CLEAR_SYNC;
            S_CLEAR_SYNC: begin
               if (sts.clear_last) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.load = (state_ff == S_IDLE) && start && !busy_ff;
      unique case (state_ff)
         S_CLEAR_BOOT: cmd.clear      = 1'b1;
         S_A_CLASS:    cmd.arr_class  = 1'b1;
         S_A_FILL:     cmd.arr_fill   = 1'b1;
         S_A_STORE:    cmd.arr_store  = 1'b1;
         S_A_READ:     cmd.mem_rd     = 1'b1;
         S_A_CHK: begin
            cmd.arr_chk = 1'b1;
            cmd.emit    = 1'b1;
         end
         S_F_DECIDE:   cmd.fet_decide = 1'b1;
         S_F_INC:      cmd.fet_inc    = 1'b1;
         S_F_READ:     cmd.mem_rd     = 1'b1;
         S_F_PLAY: begin
            cmd.fet_play = 1'b1;
            cmd.emit     = 1'b1;
         end
         S_RESYNC:     cmd.resync     = 1'b1;
         S_CLEAR_SYNC: cmd.clear      = 1'b1;
         S_EMIT:       cmd.emit       = 1'b1;
         default:      cmd.load       = cmd.load;
      endcase
   end

   assign busy = busy_ff;

   a_emit_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> busy_ff)
      else $error("result emitted outside an item");

   a_one_mem_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.arr_store, cmd.fet_play}))
      else $error("two ready-bit writers in one cycle");

endmodule

`default_nettype wire

/* design/pjb_dpath.sv */
// datapath: pointers, flags, slot modulo pipeline, ready-bit memory and result registers
`default_nettype none

module pjb_dpath #(
   parameter int DEPTH = 512
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pjb_pkg::cmd_type                   cmd,
   output pjb_pkg::sts_type                        sts,
   input  wire logic [pjb_pkg::SEQ_W-1:0]          req_seq,
   input  wire logic                               csr_we,
   input  wire logic [pjb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pjb_pkg::CFG_W-1:0]          csr_wdata,
   output logic                                    rsp_strobe,
   output logic [pjb_pkg::STATUS_W-1:0]            rsp_status,
   output logic [$clog2(DEPTH)-1:0]                rsp_slot,
   output logic                                    rsp_overrun,
   output logic signed [pjb_pkg::SEQ_W-1:0]        rsp_fill,
   output logic                                    rsp_gap_resend,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_gap_first,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_gap_count,
   output logic                                    rsp_chance_resend,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_chance_seq,
   output logic                                    rsp_start_play
);

   localparam int SLOT_W  = $clog2(DEPTH);
   // slot = seq mod DEPTH by reciprocal: q estimate is exact or one low
   localparam int RECIP_W = 33 - $clog2(DEPTH);
   localparam int Q_W     = RECIP_W - 16;
   localparam int PROD_W  = 16 + RECIP_W;
   localparam int QD_W    = Q_W + 17;
   localparam longint unsigned RECIP = 64'h1_0000_0000 / DEPTH;
   localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
   localparam logic [16:0]        DEPTH_V   = 17'(DEPTH);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(DEPTH - 1);

   // control state
   logic [15:0]                 wp_ff;
   logic [15:0]                 rp_ff;
   logic                        synced_ff;
   logic                        buffering_ff;
   logic                        restart_ff;
   logic [pjb_pkg::CFG_W-1:0]   start_fill_ff;
   logic [pjb_pkg::CFG_W-1:0]   lookahead_ff;
   logic [SLOT_W-1:0]           clr_idx_ff;
   logic                        strobe_ff;

   // payload
   logic [15:0]                 seq_ff;
   logic                        store_ff;
   logic [15:0]                 mod_in_ff;
   logic [15:0]                 mod_in_in;
   logic [15:0]                 mod_d_ff;
   logic [Q_W-1:0]              q_ff;
   logic [16:0]                 r_ff;
   logic [SLOT_W-1:0]           slot_ff;
   logic                        ready_ff [DEPTH];
   logic                        ready_rd_ff;

   logic [pjb_pkg::STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]           res_slot_ff;
   logic                        overrun_ff;
   logic signed [15:0]          fill_ff;
   logic                        gap_resend_ff;
   logic [15:0]                 gap_first_ff;
   logic [15:0]                 gap_count_ff;
   logic                        chance_ff;
   logic [15:0]                 chance_seq_ff;
   logic                        start_play_ff;

   // combinational
   logic [15:0]                 fill;
   logic                        fill_pos;
   logic                        fill_ge_start;
   logic                        fill_ge_depth;
   logic [15:0]                 wp_sync;
   logic [15:0]                 rp_sync;
   logic [15:0]                 d_wp;
   logic [15:0]                 d_rp;
   logic                        in_order;
   logic                        after_wp;
   logic                        after_rp;
   logic [15:0]                 play_base;
   logic [15:0]                 ahead;
   logic [PROD_W-1:0]           prod;
   logic [QD_W-1:0]             qd;
   logic [SLOT_W-1:0]           slot_in;
   logic                        mem_we;
   logic [SLOT_W-1:0]           mem_addr;
   logic                        mem_wd;
   logic                        end_buffering;

   assign fill          = wp_ff - rp_ff;
   assign fill_pos      = !fill[15] && (fill != 16'd0);
   assign fill_ge_start = $signed(fill) >= $signed({7'd0, start_fill_ff});
   assign fill_ge_depth = $signed({fill[15], fill}) >= $signed(DEPTH_V);
   assign end_buffering = buffering_ff && fill_ge_start;

   // first arrival after reset or resync sets the window around itself
   assign wp_sync  = synced_ff ? wp_ff : seq_ff;
   assign rp_sync  = synced_ff ? rp_ff : seq_ff - 16'd1;
   assign d_wp     = seq_ff - wp_sync;
   assign d_rp     = seq_ff - rp_sync;
   assign in_order = seq_ff == (wp_sync + 16'd1);
   assign after_wp = !d_wp[15] && (d_wp != 16'd0);
   assign after_rp = !d_rp[15] && (d_rp != 16'd0);

   assign play_base = fill_ge_depth ? (wp_ff - {7'd0, start_fill_ff}) : rp_ff;
   assign ahead     = rp_ff + {7'd0, lookahead_ff};

   assign sts.fetch_play = !restart_ff && fill_pos && synced_ff;
   assign sts.clear_last = clr_idx_ff == SLOT_LAST;

   always_comb begin
      mod_in_in = mod_in_ff;
      if (cmd.arr_class) begin
         mod_in_in = seq_ff;
      end else if (cmd.arr_fill) begin
         mod_in_in = ahead;
      end else if (cmd.fet_decide) begin
         mod_in_in = play_base;
      end
   end

   assign prod    = PROD_W'(mod_in_ff) * PROD_W'(RECIP_V);
   assign qd      = QD_W'(q_ff) * QD_W'(DEPTH_V);
   assign slot_in = (r_ff >= DEPTH_V) ? SLOT_W'(r_ff - DEPTH_V) : SLOT_W'(r_ff);

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = slot_ff;
      mem_wd   = 1'b0;
      if (cmd.clear) begin
         mem_we   = 1'b1;
         mem_addr = clr_idx_ff;
      end else if (cmd.arr_store) begin
         mem_we = store_ff;
         mem_wd = 1'b1;
      end else if (cmd.fet_play) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         rp_ff         <= '0;
         synced_ff     <= 1'b0;
         buffering_ff  <= 1'b1;
         restart_ff    <= 1'b0;
         start_fill_ff <= pjb_pkg::START_FILL_RST;
         lookahead_ff  <= pjb_pkg::LOOKAHEAD_RST;
         clr_idx_ff    <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
         if (csr_we) begin
            unique case (csr_index)
               pjb_pkg::CSR_START_FILL: start_fill_ff <= csr_wdata;
               pjb_pkg::CSR_LOOKAHEAD:  lookahead_ff  <= csr_wdata;
               default:                 lookahead_ff  <= lookahead_ff;
            endcase
         end
         if (cmd.arr_class) begin
            wp_ff     <= (in_order || after_wp) ? seq_ff : wp_sync;
            rp_ff     <= rp_sync;
            synced_ff <= 1'b1;
         end
         if (cmd.arr_fill && end_buffering) begin
            buffering_ff <= 1'b0;
         end
         if (cmd.fet_decide) begin
            if (restart_ff) begin
               if (!buffering_ff) begin
                  rp_ff      <= rp_ff + 16'd1;
                  restart_ff <= 1'b0;
               end
            end else if (!fill_pos || !synced_ff) begin
               buffering_ff <= 1'b1;
               restart_ff   <= 1'b1;
            end else begin
               rp_ff <= play_base;
            end
         end
         if (cmd.fet_inc) begin
            rp_ff <= rp_ff + 16'd1;
         end
         if (cmd.resync) begin
            synced_ff <= 1'b0;
         end
         if (cmd.clear) begin
            clr_idx_ff <= sts.clear_last ? '0 : clr_idx_ff + 1'b1;
         end
      end
   end

   // slot modulo pipeline: product, remainder, correction
   always_ff @(posedge clock) begin
      mod_in_ff <= mod_in_in;
      mod_d_ff  <= mod_in_ff;
      q_ff      <= prod[PROD_W-1:32];
      r_ff      <= {1'b0, mod_d_ff} - qd[16:0];
      slot_ff   <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ready_ff[mem_addr] <= mem_wd;
      end
      if (cmd.mem_rd) begin
         ready_rd_ff <= ready_ff[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff        <= req_seq;
         status_ff     <= pjb_pkg::ST_INORDER;
         res_slot_ff   <= '0;
         overrun_ff    <= 1'b0;
         gap_resend_ff <= 1'b0;
         gap_first_ff  <= '0;
         gap_count_ff  <= '0;
         chance_ff     <= 1'b0;
         chance_seq_ff <= '0;
         start_play_ff <= 1'b0;
      end
      if (cmd.arr_class) begin
         store_ff <= in_order || after_wp || after_rp;
         if (in_order) begin
            status_ff <= pjb_pkg::ST_INORDER;
         end else if (after_wp) begin
            status_ff     <= pjb_pkg::ST_GAP;
            gap_resend_ff <= 1'b1;
            gap_first_ff  <= wp_sync;
            gap_count_ff  <= d_wp;
         end else if (after_rp) begin
            status_ff <= pjb_pkg::ST_LATEOK;
         end else begin
            status_ff <= pjb_pkg::ST_TOOLATE;
         end
      end
      if (cmd.arr_fill && end_buffering) begin
         start_play_ff <= 1'b1;
      end
      if (cmd.arr_store && store_ff) begin
         res_slot_ff <= slot_ff;
      end
      // last-chance resend: slot ahead of playout not yet filled
      if (cmd.arr_chk && !buffering_ff && !ready_rd_ff) begin
         chance_ff     <= 1'b1;
         chance_seq_ff <= ahead;
      end
      if (cmd.fet_decide) begin
         if (restart_ff) begin
            status_ff <= buffering_ff ? pjb_pkg::ST_WAITING : pjb_pkg::ST_RESTARTED;
         end else if (!fill_pos || !synced_ff) begin
            status_ff <= pjb_pkg::ST_UNDERRUN;
         end else begin
            overrun_ff <= fill_ge_depth;
         end
      end
      if (cmd.fet_play) begin
         status_ff   <= ready_rd_ff ? pjb_pkg::ST_PLAYED : pjb_pkg::ST_MISSING;
         res_slot_ff <= slot_ff;
      end
      if (cmd.resync) begin
         status_ff <= pjb_pkg::ST_RESYNCED;
      end
      if (cmd.emit) begin
         fill_ff <= $signed(fill);
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot          = res_slot_ff;
   assign rsp_overrun       = overrun_ff;
   assign rsp_fill          = fill_ff;
   assign rsp_gap_resend    = gap_resend_ff;
   assign rsp_gap_first     = gap_first_ff;
   assign rsp_gap_count     = gap_count_ff;
   assign rsp_chance_resend = chance_ff;
   assign rsp_chance_seq    = chance_seq_ff;
   assign rsp_start_play    = start_play_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

   a_synced_after_arrival: assert property (@(posedge clock) disable iff (reset)
      cmd.arr_class |=> synced_ff)
      else $error("arrival left the window unsynced");

   a_gap_status: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && gap_resend_ff) |-> (status_ff == pjb_pkg::ST_GAP))
      else $error("gap request without gap status");

endmodule

`default_nettype wire

/* design/packet_jitter_buffer_control.sv */
// top level of the jitter buffer sequence-window controller
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ----------------------------------
//  request   req_func, req_seq                       taken on start && !busy
//  response  rsp_status ... rsp_start_play           one cycle, marked by rsp_strobe
//  config    csr_index, csr_wdata                    written on csr_we
//
// arrival: states A_CLASS through A_CHK, with the result strobe registered from A_CHK
// fetch: F_DECIDE to F_PLAY when played; EMIT for underrun, waiting or restarted
// resync: S_RESYNC, then the one-entry-per-cycle ready-bit clear, then S_EMIT
// the 3-stage slot modulo pipeline and the registered ready-bit read set the item length
// after reset busy stays high while the ready bits are cleared
// a new item is taken in the cycle its predecessor's result is on the response ports
`default_nettype none

module packet_jitter_buffer_control #(
   parameter int DEPTH = 512
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [pjb_pkg::FUNC_W-1:0]         req_func,
   input  wire logic [pjb_pkg::SEQ_W-1:0]          req_seq,
   output logic                                    rsp_strobe,
   output logic [pjb_pkg::STATUS_W-1:0]            rsp_status,
   output logic [$clog2(DEPTH)-1:0]                rsp_slot,
   output logic                                    rsp_overrun,
   output logic signed [pjb_pkg::SEQ_W-1:0]        rsp_fill,
   output logic                                    rsp_gap_resend,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_gap_first,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_gap_count,
   output logic                                    rsp_chance_resend,
   output logic [pjb_pkg::SEQ_W-1:0]               rsp_chance_seq,
   output logic                                    rsp_start_play,
   input  wire logic                               csr_we,
   input  wire logic [pjb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pjb_pkg::CFG_W-1:0]          csr_wdata
);

   pjb_pkg::cmd_type cmd;
   pjb_pkg::sts_type sts;

   pjb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   pjb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_seq           (req_seq),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_overrun       (rsp_overrun),
      .rsp_fill          (rsp_fill),
      .rsp_gap_resend    (rsp_gap_resend),
      .rsp_gap_first     (rsp_gap_first),
      .rsp_gap_count     (rsp_gap_count),
      .rsp_chance_resend (rsp_chance_resend),
      .rsp_chance_seq    (rsp_chance_seq),
      .rsp_start_play    (rsp_start_play)
   );

endmodule

`default_nettype wire
